// ----- rtl/envelope_follower_assert.svh -----
// Assertion macros shared by the envelope follower RTL.
// Depends on nothing; the including module supplies clock, reset and signals.
`ifndef ENVELOPE_FOLLOWER_ASSERT_SVH
`define ENVELOPE_FOLLOWER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ENVF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ENVF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/envf_pkg.sv -----
// Shared constants, register indexes and interface structs of the envelope follower.
// Depends on nothing; every RTL module imports it.
package envf_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COEFF_W      = 16;
    localparam int STATE_W      = 17;
    localparam int CFG_IDX_W    = 8;

    // Signed multiplicand width: wide enough for the sample magnitude and
    // for a signed difference of two envelope states.
    localparam int MC_W  = (SAMPLE_WIDTH + 1 > STATE_W + 1) ? SAMPLE_WIDTH + 1 : STATE_W + 1;
    localparam int HI_W  = MC_W + 1;
    localparam int MP_W  = COEFF_W;
    localparam int CNT_W = $clog2(MP_W);

    localparam logic [COEFF_W-1:0] SMOOTH_COEFF = 16'd3277;
    localparam logic [STATE_W-1:0] ONE_Q16      = 17'd65536;

    localparam logic [COEFF_W-1:0] RST_ATTACK = 16'd53215;
    localparam logic [COEFF_W-1:0] RST_DECAY  = 16'd64184;
    localparam logic [COEFF_W-1:0] RST_SENS   = 16'd32768;
    localparam logic [COEFF_W-1:0] RST_DEPTH  = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 8'd3;

    typedef struct packed {
        logic [COEFF_W-1:0] attack;
        logic [COEFF_W-1:0] decay;
        logic [COEFF_W-1:0] sens;
        logic [COEFF_W-1:0] depth;
    } t_cfg;

    typedef struct packed {
        logic            start;
        logic [MC_W-1:0] mcand;
        logic [MP_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic            done;
        logic [HI_W-1:0] hi;
        logic [MP_W-1:0] lo;
    } t_mul_rsp;

endpackage

// ----- rtl/envf_mul.sv -----
// Serial-parallel multiplier: signed multiplicand times unsigned multiplier, one bit a cycle.
// Depends on envf_pkg and envelope_follower_assert.svh.
`include "envelope_follower_assert.svh"

module envf_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  envf_pkg::t_mul_req i_req,
    output envf_pkg::t_mul_rsp o_rsp
);
    import envf_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(MP_W - 1);

    logic [MC_W-1:0]  r_mc;
    logic [MP_W-1:0]  r_mp, n_mp;
    logic [HI_W-1:0]  r_hi, n_hi;
    logic [MP_W-1:0]  r_lo, n_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [HI_W-1:0]  mc_ext;
    logic [HI_W-1:0]  sum;

    // One partial product per cycle; the sum shifts right into the low word.
    always_comb begin
        mc_ext = {r_mc[MC_W-1], r_mc};
        sum    = r_hi + (r_mp[0] ? mc_ext : '0);
        n_hi   = {sum[HI_W-1], sum[HI_W-1:1]};
        n_lo   = {sum[0], r_lo[MP_W-1:1]};
        n_mp   = {1'b0, r_mp[MP_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= (r_cnt != LAST);
            r_done <= (r_cnt == LAST);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mc <= i_req.mcand;
            r_mp <= i_req.mplier;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_mp <= n_mp;
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = r_lo;

    `ENVF_ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, i_req.start, !r_busy, "multiplier restarted while busy")
    `ENVF_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "multiplier done while busy")

endmodule

// ----- rtl/envf_seq.sv -----
// Sequencer of the envelope follower: holds both envelope states and the result register, and steps
// the shared serial multiplier through the four products. Depends on envf_pkg and envelope_follower_assert.svh.
`include "envelope_follower_assert.svh"

module envf_seq (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  envf_pkg::t_cfg                       i_cfg,
    input  logic                                 i_start,
    input  logic [envf_pkg::SAMPLE_WIDTH-1:0]    i_sample,
    output logic                                 o_idle,
    output envf_pkg::t_mul_req                   o_req,
    input  envf_pkg::t_mul_rsp                   i_rsp,
    output logic                                 o_res_valid,
    output logic [envf_pkg::COEFF_W-1:0]         o_res_value,
    input  logic                                 i_res_take
);
    import envf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAG  = 6'b000010,
        S_ENV  = 6'b000100,
        S_SM   = 6'b001000,
        S_OUT  = 6'b010000,
        S_WB   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [STATE_W-1:0]   r_env, n_env;
    logic [STATE_W-1:0]   r_sm, n_sm;
    logic [STATE_W-1:0]   r_mag, n_mag;
    logic                 r_res_valid, n_res_valid;
    logic [COEFF_W-1:0]   r_res_value, n_res_value;

    logic [SAMPLE_WIDTH:0]    s_ext;
    logic [SAMPLE_WIDTH:0]    abs_val;
    logic [HI_W+MP_W-1:0]     full;
    logic [STATE_W-1:0]       mag_now;
    logic [STATE_W-1:0]       base;
    logic [HI_W:0]            blend_sum;
    logic [STATE_W-1:0]       blend;
    logic [STATE_W-1:0]       capped;
    logic                     res_free;

    always_comb begin
        // Magnitude of the sample; the most negative code maps to exactly 1.0.
        s_ext   = {i_sample[SAMPLE_WIDTH-1], i_sample};
        abs_val = s_ext[SAMPLE_WIDTH] ? (~s_ext + 1'b1) : s_ext;

        full    = {i_rsp.hi, i_rsp.lo};
        mag_now = full[SAMPLE_WIDTH-1 +: STATE_W];

        // Pole update: base + high word of coeff*(target - base), rounded by the
        // top bit of the low word.
        base      = (r_state == S_ENV) ? r_mag : r_sm;
        blend_sum = {{(HI_W + 1 - STATE_W){1'b0}}, base} + {i_rsp.hi[HI_W-1], i_rsp.hi}
                    + {{HI_W{1'b0}}, i_rsp.lo[MP_W-1]};
        blend     = blend_sum[STATE_W-1:0];
        capped    = (blend > ONE_Q16) ? ONE_Q16 : blend;
        res_free  = !r_res_valid || i_res_take;
    end

    always_comb begin
        n_state     = r_state;
        n_env       = r_env;
        n_sm        = r_sm;
        n_mag       = r_mag;
        n_res_valid = (r_res_valid && i_res_take) ? 1'b0 : r_res_valid;
        n_res_value = r_res_value;
        o_req.start  = 1'b0;
        o_req.mcand  = '0;
        o_req.mplier = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_req.start  = 1'b1;
                    o_req.mcand  = MC_W'(abs_val);
                    o_req.mplier = i_cfg.sens;
                    n_state      = S_MAG;
                end
            end
            S_MAG: begin
                if (i_rsp.done) begin
                    n_mag        = mag_now;
                    o_req.start  = 1'b1;
                    o_req.mcand  = MC_W'(r_env) - MC_W'(mag_now);
                    o_req.mplier = (mag_now > r_env) ? i_cfg.attack : i_cfg.decay;
                    n_state      = S_ENV;
                end
            end
            S_ENV: begin
                if (i_rsp.done) begin
                    n_env        = blend;
                    o_req.start  = 1'b1;
                    o_req.mcand  = MC_W'(blend) - MC_W'(r_sm);
                    o_req.mplier = SMOOTH_COEFF;
                    n_state      = S_SM;
                end
            end
            S_SM: begin
                if (i_rsp.done) begin
                    n_sm         = blend;
                    o_req.start  = 1'b1;
                    o_req.mcand  = MC_W'(capped);
                    o_req.mplier = i_cfg.depth;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (i_rsp.done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                // The product stays put in the multiplier until the slot frees up.
                if (res_free) begin
                    n_res_valid = 1'b1;
                    n_res_value = i_rsp.hi[COEFF_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_env       <= '0;
            r_sm        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_env       <= n_env;
            r_sm        <= n_sm;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_res_value <= n_res_value;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res_value = r_res_value;

    `ENVF_ASSERT_NEXT(a_start_mag, i_clk, i_rst_n, i_start && o_idle, r_state == S_MAG, "accepted sample did not start magnitude step")
    `ENVF_ASSERT_IMPL(a_done_busy, i_clk, i_rst_n, i_rsp.done, !o_idle && (r_state != S_WB), "product finished outside a multiply step")
    `ENVF_ASSERT_IMPL(a_res_from_wb, i_clk, i_rst_n, $rose(r_res_valid), $past(r_state == S_WB), "result appeared outside write-back")

endmodule

// ----- rtl/envelope_follower.sv -----
// Top level of the attack/release envelope follower: configuration registers and ports.
// Depends on envf_pkg, envf_mul and envf_seq.

// One sample beat in gives one control_value beat out. From acceptance to result, four
// products (scaled magnitude, envelope update, smoothing, depth scaling) run one after
// another on a single bit-serial multiplier that retires one multiplier bit per cycle;
// each product is handed on to the next step, and the last one loads the result register.
// A new sample is taken as soon as the previous one has left the multiplier, even while
// its result still waits in the output register. Configuration writes are always ready
// and take effect on the next sample when made while the block is idle; indexes 0 to 3
// select attack_coeff, decay_coeff, sensitivity and depth, and writes to any other
// index are dropped. All arithmetic is fixed point: samples Q1.15, registers Q0.16,
// envelope states Q1.16, output Q0.16.
module envelope_follower (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_sample_valid,
    output logic                               o_sample_ready,
    input  logic [envf_pkg::SAMPLE_WIDTH-1:0]  i_sample,
    output logic                               o_result_valid,
    input  logic                               i_result_ready,
    output logic [envf_pkg::COEFF_W-1:0]       o_control_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [envf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [envf_pkg::COEFF_W-1:0]       i_cfg_data
);
    import envf_pkg::*;

    t_cfg     r_cfg, n_cfg;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    logic     seq_idle;

    // Register file write. Software must write here only while the block is idle; the block does not enforce it.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATTACK: n_cfg.attack = i_cfg_data;
                CFG_DECAY:  n_cfg.decay  = i_cfg_data;
                CFG_SENS:   n_cfg.sens   = i_cfg_data;
                CFG_DEPTH:  n_cfg.depth  = i_cfg_data;
                default:    n_cfg        = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack <= RST_ATTACK;
            r_cfg.decay  <= RST_DECAY;
            r_cfg.sens   <= RST_SENS;
            r_cfg.depth  <= RST_DEPTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_sample_ready = seq_idle;

    // The sequencer owns both envelope states and the output register.
    envf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (i_sample_valid && seq_idle),
        .i_sample    (i_sample),
        .o_idle      (seq_idle),
        .o_req       (mul_req),
        .i_rsp       (mul_rsp),
        .o_res_valid (o_result_valid),
        .o_res_value (o_control_value),
        .i_res_take  (i_result_ready)
    );

    // Shared shift-add multiplier, one multiplier bit per cycle.
    envf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

endmodule

// ----- test/envelope_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the envelope follower: watches the sample, result and register write channels.
// Depends on envf_pkg for widths, register indexes and reset values.
module envelope_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_sample_valid,
    input  logic                               i_sample_ready,
    input  logic [envf_pkg::SAMPLE_WIDTH-1:0]  i_sample,
    input  logic                               i_result_valid,
    input  logic                               i_result_ready,
    input  logic [envf_pkg::COEFF_W-1:0]       i_control_value,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [envf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [envf_pkg::COEFF_W-1:0]       i_cfg_data,
    output int                                 o_pending,
    output int                                 o_mismatches
);

    localparam int SW = envf_pkg::SAMPLE_WIDTH;
    localparam logic [16:0] UNITY = envf_pkg::ONE_Q16;
    localparam logic [16:0] SMOOTH_HOLD = UNITY - 17'(envf_pkg::SMOOTH_COEFF);

    logic [15:0] attack_q, decay_q, sens_q, depth_q;
    logic [16:0] env_q, smooth_q;
    logic [15:0] control_fifo[$];
    logic [15:0] want;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        o_mismatches++;
    endtask

    // Rounded one-pole blend of the held state toward the target.
    function automatic logic [16:0] blend_pole(input logic [16:0] coeff, input logic [16:0] held,
                                               input logic [16:0] target);
        logic [49:0] acc;
        acc = 50'(coeff) * 50'(held) + 50'(UNITY - coeff) * 50'(target) + 50'd32768;
        return acc[32:16];
    endfunction

    // Advances both envelope states by one sample and queues the control value it yields.
    task automatic follow_sample(input logic [SW-1:0] raw);
        logic [SW:0]   mag_in;
        logic [SW+16:0] scaled;
        logic [16:0]   mag, capped;
        logic [15:0]   coeff;
        logic [33:0]   prod;
        mag_in = raw[SW-1] ? ((SW+1)'(1) << SW) - (SW+1)'(raw) : (SW+1)'(raw);
        scaled = (SW+17)'(mag_in) * (SW+17)'(sens_q);
        mag    = 17'(scaled >> (SW - 1));
        coeff  = (mag > env_q) ? attack_q : decay_q;
        env_q    = blend_pole({1'b0, coeff}, env_q, mag);
        smooth_q = blend_pole(SMOOTH_HOLD, smooth_q, env_q);
        capped = (smooth_q > UNITY) ? UNITY : smooth_q;
        prod   = 34'(capped) * 34'(depth_q);
        control_fifo.push_back((prod[33:16] > 18'd65535) ? 16'hFFFF : prod[31:16]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            attack_q = envf_pkg::RST_ATTACK;
            decay_q  = envf_pkg::RST_DECAY;
            sens_q   = envf_pkg::RST_SENS;
            depth_q  = envf_pkg::RST_DEPTH;
            env_q    = '0;
            smooth_q = '0;
            control_fifo.delete();
        end else begin
            // Results are older than any sample taken at the same edge, so check them first.
            if (i_result_valid && i_result_ready) begin
                if (control_fifo.size() == 0) begin
                    report_mismatch($sformatf("control_value %0d with no sample outstanding",
                                              i_control_value));
                end else begin
                    want = control_fifo.pop_front();
                    if (i_control_value !== want)
                        report_mismatch($sformatf("control_value got %0d, expected %0d",
                                                  i_control_value, want));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    envf_pkg::CFG_ATTACK: attack_q = i_cfg_data;
                    envf_pkg::CFG_DECAY:  decay_q  = i_cfg_data;
                    envf_pkg::CFG_SENS:   sens_q   = i_cfg_data;
                    envf_pkg::CFG_DEPTH:  depth_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_sample_valid && i_sample_ready)
                follow_sample(i_sample);
        end
        o_pending = control_fifo.size();
    end

endmodule

// ----- test/tb_envelope_follower.sv -----
`timescale 1ns / 1ps
// Top of the envelope follower testbench: clock, reset, sample and register stimulus, verdict.
// Depends on envf_pkg, the envelope_follower RTL and envelope_checker.
module tb_envelope_follower;

    // Upper bound on the run length, with ample margin over the slowest legal run.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 105;
    localparam int SETTINGS_CNT = 8;
    localparam int SW           = envf_pkg::SAMPLE_WIDTH;

    // Indexes that decode to no register; writes to them must be dropped.
    localparam logic [envf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 8'd4;
    localparam logic [envf_pkg::CFG_IDX_W-1:0] CFG_LAST  = 8'hFF;

    // Character of a burst of samples: loud bursts drive the attack path, silence and
    // quiet passages the decay path, peaks hit the extreme codes of the sample.
    typedef enum int {
        TONE_LOUD,
        TONE_QUIET,
        TONE_FULL,
        TONE_PEAKS,
        TONE_SILENCE
    } t_tone;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              sample_valid = 1'b0;
    logic                              sample_ready;
    logic [SW-1:0]                     sample = '0;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    logic [envf_pkg::COEFF_W-1:0]      control_value;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [envf_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [envf_pkg::COEFF_W-1:0]      cfg_data = '0;
    int                                pending;
    int                                mismatches;
    int                                cycle_count = 0;

    always #5 clk = ~clk;

    envelope_follower dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_sample_valid  (sample_valid),
        .o_sample_ready  (sample_ready),
        .i_sample        (sample),
        .o_result_valid  (result_valid),
        .i_result_ready  (result_ready),
        .o_control_value (control_value),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    envelope_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_sample_valid  (sample_valid),
        .i_sample_ready  (sample_ready),
        .i_sample        (sample),
        .i_result_valid  (result_valid),
        .i_result_ready  (result_ready),
        .i_control_value (control_value),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_pending       (pending),
        .o_mismatches    (mismatches)
    );

    // Idle length for either side: mostly none or a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 16);
        else
            return $urandom_range(17, 90);
    endfunction

    function automatic logic [SW-1:0] make_sample(input t_tone tone);
        logic [SW-1:0] mag;
        logic          neg;
        neg = 1'($urandom_range(0, 1));
        case (tone)
            TONE_LOUD:  mag = SW'($urandom_range(8192, 32767));
            TONE_QUIET: mag = SW'($urandom_range(0, 600));
            TONE_FULL:  return SW'($urandom);
            TONE_PEAKS: begin
                case ($urandom_range(0, 5))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h8001;
                    3: return 16'hFFFF;
                    4: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            default:    return '0;
        endcase
        return neg ? SW'(0) - mag : mag;
    endfunction

    // Sends one sample beat after the given number of idle cycles. Valid stays high from one
    // beat to the next when there is no gap, so back-to-back beats are not split.
    task automatic push_sample(input logic [SW-1:0] value, input int gap);
        if (gap > 0) begin
            @(negedge clk);
            sample_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid = 1'b1;
        sample       = value;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [envf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [envf_pkg::COEFF_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Holds the sender off until every outstanding control value has been returned.
    task automatic wait_drained();
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Register settings: the first few pin the extremes, including a sensitivity below its
    // nominal floor, one restores the reset values and the rest are random. Each also
    // writes an index that selects no register, which must leave all settings unchanged.
    task automatic load_setting(input int n);
        logic [15:0] a, d, s, g;
        a = 16'($urandom_range(0, 65535));
        d = 16'($urandom_range(0, 65535));
        s = 16'($urandom_range(0, 65535));
        g = 16'($urandom_range(0, 65535));
        case (n)
            0: begin a = 16'h0000; d = 16'h0000; s = 16'hFFFF; g = 16'hFFFF; end
            1: begin a = 16'hFFFF; d = 16'hFFFF; s = 16'h0000; g = 16'h0000; end
            2: begin a = 16'hFFFF; d = 16'h0000; s = 16'd655;  g = 16'hFFFF; end
            3: begin a = 16'h0000; d = 16'hFFFF; s = 16'hFFFF; g = 16'h0001; end
            4: begin
                a = envf_pkg::RST_ATTACK;
                d = envf_pkg::RST_DECAY;
                s = envf_pkg::RST_SENS;
                g = envf_pkg::RST_DEPTH;
            end
            default: ;
        endcase
        write_reg(envf_pkg::CFG_ATTACK, a);
        write_reg(envf_pkg::CFG_DECAY, d);
        write_reg(n[0] ? CFG_SPARE : CFG_LAST, 16'($urandom));
        write_reg(envf_pkg::CFG_SENS, s);
        write_reg(envf_pkg::CFG_DEPTH, g);
    endtask

    // Random samples in bursts of one character. A quarter of the bursts run with no gaps.
    task automatic run_bursts(input int count);
        int    left;
        bit    steady;
        t_tone tone;
        left   = 0;
        steady = 1'b0;
        tone   = TONE_FULL;
        for (int i = 0; i < count; i++) begin
            if (left == 0) begin
                tone   = t_tone'($urandom_range(0, 4));
                left   = $urandom_range(5, 40);
                steady = ($urandom_range(0, 3) == 0);
            end
            push_sample(make_sample(tone), steady ? 0 : pick_gap());
            left--;
        end
    endtask

    // Result side: random stalls at a rate that is redrawn periodically, with
    // stretches where the result channel never stalls at all.
    initial begin
        int hold;
        int cyc;
        int stall_pct;
        hold      = 0;
        cyc       = 0;
        stall_pct = 20;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 400 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    default: stall_pct = 60;
                endcase
            end
            if (hold > 0) begin
                result_ready = 1'b0;
                hold--;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                result_ready = 1'b0;
                hold = pick_gap();
            end else begin
                result_ready = 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats at the reset settings: full-scale attack, the most negative code,
        // the smallest magnitudes, silence to let the envelope decay, then two bit patterns.
        push_sample(16'h7FFF, 0);
        push_sample(16'h7FFF, 0);
        push_sample(16'h7FFF, 0);
        push_sample(16'h8000, 0);
        push_sample(16'h8001, 0);
        push_sample(16'hFFFF, 0);
        push_sample(16'h0001, 0);
        push_sample(16'h0000, 0);
        push_sample(16'h0000, 0);
        push_sample(16'h0000, 0);
        push_sample(16'h5555, 0);
        push_sample(16'hAAAA, 0);
        run_bursts(PHASE_ITEMS - 12);

        // Each register setting starts from an idle block.
        for (int n = 0; n < SETTINGS_CNT; n++) begin
            wait_drained();
            load_setting(n);
            run_bursts(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/envf_pkg.sv
rtl/envf_mul.sv
rtl/envf_seq.sv
rtl/envelope_follower.sv
test/envelope_checker.sv
test/tb_envelope_follower.sv
